/* rtl/vn2d_pkg.sv */
// vn2d_pkg: widths and codes shared by the value noise core and its bench.
// No dependencies.
package vn2d_pkg;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int unsigned VALUE_W     = 8;
   localparam int unsigned COORD_W     = 16;
   localparam int unsigned FRAC_W      = 8;
   localparam int unsigned SQ_W        = 2 * FRAC_W;
   localparam int unsigned SLOPE_W     = FRAC_W + 2;
   localparam int unsigned SHAPE_W     = 16;
   localparam int unsigned WEIGHT_W    = SHAPE_W + 1;
   localparam int unsigned ROW_W       = VALUE_W + SHAPE_W;
   localparam int unsigned TOTAL_W     = ROW_W + SHAPE_W;
   localparam int unsigned LEVEL_W     = 16;

   // 3 - 2f scaled by 256
   localparam logic [SLOPE_W-1:0]  SHAPE_BASE = SLOPE_W'(768);
   // 1.0 in Q1.16
   localparam logic [WEIGHT_W-1:0] ONE_Q16    = WEIGHT_W'(65536);

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

endpackage

/* rtl/vn2d_ram.sv */
// vn2d_ram: generic RAM, one write port, two read ports, registered read data.
// Read returns the contents before a write at the same edge. No dependencies.
module vn2d_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* rtl/value_noise_2d_core.sv */
// value_noise_2d_core: 2D lattice value noise with smoothstep shaping, Q8.8 in and out.
// Depends on vn2d_pkg and vn2d_ram.
//
// One input word is taken every cycle while req_stall is low. A load word writes one
// permutation table entry at the edge it is accepted and gives no result; an evaluate
// word presents one result on rsp_valid from the output register. The four register stages
// are: first table lookup and fraction squares, second table lookup and smoothstep
// weights, the two row blends, and the column blend into the output register. The table
// is held in three identical RAM copies that every load writes, so both lookup levels are
// served in the same cycle. A result that waits on rsp_stall holds only the output register;
// earlier stages keep filling until the pipeline is full, and only then is req_stall
// raised.
module value_noise_2d_core
   import vn2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [TABLE_AW-1:0] req_table_index,
   input  logic [VALUE_W-1:0] req_table_value,
   input  logic [COORD_W-1:0] req_coord_x,
   input  logic [COORD_W-1:0] req_coord_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [LEVEL_W-1:0] rsp_noise_level
);

   logic en1, en2, en3, en4;
   logic accept, load_we;

   // stage 1
   logic                v1_ff, v1_in;
   logic [SQ_W-1:0]     sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SLOPE_W-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic [TABLE_AW-1:0] iy_ff, iy_in;
   logic [TABLE_AW-1:0] ix0, ix1;
   logic [VALUE_W-1:0]  pa0, pa1;

   // stage 2
   logic                        v2_ff, v2_in;
   logic [SHAPE_W-1:0]          sx_ff, sx_in, sy_ff, sy_in;
   logic [SQ_W+SLOPE_W-1:0]     prod_x, prod_y;
   logic [TABLE_AW-1:0]         iy1;
   logic [VALUE_W-1:0]          c00, c01, c10, c11;

   // stage 3
   logic                 v3_ff, v3_in;
   logic [ROW_W-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [SHAPE_W-1:0]   sy3_ff, sy3_in;
   logic [WEIGHT_W-1:0]  wx;

   // stage 4
   logic                 v4_ff, v4_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [WEIGHT_W-1:0]  wy;
   logic [TOTAL_W-1:0]   total;

   assign en4       = !v4_ff || !rsp_stall;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;
   assign load_we   = accept && (req_action == ACT_LOAD);

   // stage 1: first lookup, fraction squares
   assign ix0    = req_coord_x[COORD_W-1:FRAC_W];
   assign ix1    = ix0 + TABLE_AW'(1);
   assign v1_in  = accept && (req_action == ACT_EVAL);
   assign sqx_in = SQ_W'(req_coord_x[FRAC_W-1:0]) * SQ_W'(req_coord_x[FRAC_W-1:0]);
   assign sqy_in = SQ_W'(req_coord_y[FRAC_W-1:0]) * SQ_W'(req_coord_y[FRAC_W-1:0]);
   assign mx_in  = SHAPE_BASE - {1'b0, req_coord_x[FRAC_W-1:0], 1'b0};
   assign my_in  = SHAPE_BASE - {1'b0, req_coord_y[FRAC_W-1:0], 1'b0};
   assign iy_in  = req_coord_y[COORD_W-1:FRAC_W];

   vn2d_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_ram_row (
      .clock     (clock),
      .wr_en     (load_we),
      .wr_addr   (req_table_index),
      .wr_data   (req_table_value),
      .rd_en     (en1),
      .rd_addr_a (ix0),
      .rd_addr_b (ix1),
      .rd_data_a (pa0),
      .rd_data_b (pa1)
   );

   // stage 2: corner lookups, smoothstep weights
   assign iy1    = iy_ff + TABLE_AW'(1);
   assign v2_in  = v1_ff;
   assign prod_x = (SQ_W+SLOPE_W)'(sqx_ff) * (SQ_W+SLOPE_W)'(mx_ff);
   assign prod_y = (SQ_W+SLOPE_W)'(sqy_ff) * (SQ_W+SLOPE_W)'(my_ff);
   assign sx_in  = prod_x[SHAPE_W+FRAC_W-1:FRAC_W];
   assign sy_in  = prod_y[SHAPE_W+FRAC_W-1:FRAC_W];

   vn2d_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_ram_c0 (
      .clock     (clock),
      .wr_en     (load_we),
      .wr_addr   (req_table_index),
      .wr_data   (req_table_value),
      .rd_en     (en2),
      .rd_addr_a (pa0 + iy_ff),
      .rd_addr_b (pa0 + iy1),
      .rd_data_a (c00),
      .rd_data_b (c01)
   );

   vn2d_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_ram_c1 (
      .clock     (clock),
      .wr_en     (load_we),
      .wr_addr   (req_table_index),
      .wr_data   (req_table_value),
      .rd_en     (en2),
      .rd_addr_a (pa1 + iy_ff),
      .rd_addr_b (pa1 + iy1),
      .rd_data_a (c10),
      .rd_data_b (c11)
   );

   // stage 3: blend along x, Q8.16
   assign wx     = ONE_Q16 - WEIGHT_W'(sx_ff);
   assign v3_in  = v2_ff;
   assign lo_in  = ROW_W'(ROW_W'(c00) * ROW_W'(wx) + ROW_W'(c10) * ROW_W'(sx_ff));
   assign hi_in  = ROW_W'(ROW_W'(c01) * ROW_W'(wx) + ROW_W'(c11) * ROW_W'(sx_ff));
   assign sy3_in = sy_ff;

   // stage 4: blend along y, Q8.32 truncated to Q8.8
   assign wy       = ONE_Q16 - WEIGHT_W'(sy3_ff);
   assign total    = TOTAL_W'(lo_ff) * TOTAL_W'(wy) + TOTAL_W'(hi_ff) * TOTAL_W'(sy3_ff);
   assign v4_in    = v3_ff;
   assign level_in = total[TOTAL_W-1:TOTAL_W-LEVEL_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= v1_in;
         end
         if (en2) begin
            v2_ff <= v2_in;
         end
         if (en3) begin
            v3_ff <= v3_in;
         end
         if (en4) begin
            v4_ff <= v4_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         iy_ff  <= iy_in;
      end
      if (en2) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (en3) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         sy3_ff <= sy3_in;
      end
      if (en4) begin
         level_ff <= level_in;
      end
   end

   assign rsp_valid       = v4_ff;
   assign rsp_noise_level = level_ff;

endmodule

/* bench/value_noise_2d_checker.sv */
// value_noise_2d_checker: watches the request and response channels of value_noise_2d_core,
// keeps its own copy of the permutation table and predicts every noise level in order.
// Depends on vn2d_pkg.
`timescale 1ns / 100ps

module value_noise_2d_checker
   import vn2d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_action,
   input  logic [TABLE_AW-1:0] req_table_index,
   input  logic [VALUE_W-1:0]  req_table_value,
   input  logic [COORD_W-1:0]  req_coord_x,
   input  logic [COORD_W-1:0]  req_coord_y,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [LEVEL_W-1:0]  rsp_noise_level,
   output int                  fault_count,
   output int                  levels_owed
);

   logic [VALUE_W-1:0] perm_copy [TABLE_DEPTH];
   logic [LEVEL_W-1:0] level_queue [$];
   logic [LEVEL_W-1:0] wanted_level;
   int                 faults = 0;

   assign fault_count = faults;
   assign levels_owed = level_queue.size();

   initial begin
      foreach (perm_copy[k]) perm_copy[k] = '0;
   end

   // f*f*(3-2f) for f = a/256, exact then truncated to Q0.16
   function automatic logic [SHAPE_W-1:0] smooth_weight(input logic [FRAC_W-1:0] a);
      logic [31:0] a_wide;
      a_wide = 32'(a);
      return SHAPE_W'((a_wide * a_wide * (32'd768 - 32'd2 * a_wide)) >> 8);
   endfunction

   function automatic logic [63:0] mix(input logic [63:0] p, input logic [63:0] q,
                                       input logic [SHAPE_W-1:0] s);
      return p * (64'd65536 - 64'(s)) + q * 64'(s);
   endfunction

   function automatic logic [63:0] lattice(input logic [7:0] i, input logic [7:0] j);
      logic [7:0] slot;
      slot = 8'(perm_copy[i] + j);
      return 64'(perm_copy[slot]);
   endfunction

   function automatic logic [LEVEL_W-1:0] predict_level(input logic [COORD_W-1:0] x,
                                                        input logic [COORD_W-1:0] y);
      logic [7:0]         ix, iy, ix_next, iy_next;
      logic [SHAPE_W-1:0] sx, sy;
      logic [63:0]        row_lo, row_hi, total;
      ix      = x[15:8];
      iy      = y[15:8];
      ix_next = ix + 8'd1;
      iy_next = iy + 8'd1;
      sx      = smooth_weight(x[7:0]);
      sy      = smooth_weight(y[7:0]);
      row_lo  = mix(lattice(ix, iy), lattice(ix_next, iy), sx);
      row_hi  = mix(lattice(ix, iy_next), lattice(ix_next, iy_next), sx);
      total   = mix(row_lo, row_hi, sy);
      return total[39:24];
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (level_queue.size() == 0) begin
               $error("noise_level: word with none expected, expected none, actual %0d",
                      rsp_noise_level);
               faults++;
            end else begin
               wanted_level = level_queue.pop_front();
               if (rsp_noise_level !== wanted_level) begin
                  $error("noise_level: expected %0d, actual %0d", wanted_level,
                         rsp_noise_level);
                  faults++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACT_LOAD) begin
               perm_copy[req_table_index] = req_table_value;
            end else begin
               level_queue.push_back(predict_level(req_coord_x, req_coord_y));
            end
         end
      end
   end

endmodule

/* bench/testbench.sv */
// testbench: drives value_noise_2d_core with table loads and noise evaluations under random
// idling on both sides and gives the verdict. Depends on vn2d_pkg and value_noise_2d_checker.
`timescale 1ns / 100ps

module testbench
   import vn2d_pkg::*;
();

   localparam int ITEM_TOTAL = 1700;
   localparam int CALM_FROM  = 1450;
   localparam int HOLD_AT    = 700;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_action = ACT_LOAD;
   logic [TABLE_AW-1:0] req_table_index = '0;
   logic [VALUE_W-1:0]  req_table_value = '0;
   logic [COORD_W-1:0]  req_coord_x = '0;
   logic [COORD_W-1:0]  req_coord_y = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]  rsp_noise_level;
   int                  fault_count;
   int                  levels_owed;

   logic [7:0] shadow [256];
   int         items_sent = 0;
   int         loads_sent = 0;
   int         evals_sent = 0;
   int         gap_mode = 1;
   bit         calm = 1'b0;
   bit         hold_wanted = 1'b0;

   always #5 clock = ~clock;

   value_noise_2d_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_table_index(req_table_index),
      .req_table_value(req_table_value),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_noise_level(rsp_noise_level)
   );

   value_noise_2d_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_table_index(req_table_index),
      .req_table_value(req_table_value),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_noise_level(rsp_noise_level),
      .fault_count    (fault_count),
      .levels_owed    (levels_owed)
   );

   task automatic send_word(input logic act, input logic [7:0] idx, input logic [7:0] val,
                            input logic [15:0] x, input logic [15:0] y);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_table_index <= idx;
      req_table_value <= val;
      req_coord_x     <= x;
      req_coord_y     <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ACT_LOAD) begin
         shadow[idx] = val;
         loads_sent++;
      end else begin
         evals_sent++;
      end
      items_sent++;
      if (items_sent % 128 == 0) gap_mode = $urandom_range(0, 2);
      if (items_sent == HOLD_AT) hold_wanted = 1'b1;
      if (items_sent >= CALM_FROM) calm = 1'b1;
      if (!calm && gap_mode != 0 && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic load_entry(input logic [7:0] idx, input logic [7:0] val);
      send_word(ACT_LOAD, idx, val, 16'($urandom), 16'($urandom));
   endtask

   task automatic evaluate(input logic [15:0] x, input logic [15:0] y);
      send_word(ACT_EVAL, 8'($urandom), 8'($urandom), x, y);
   endtask

   // response side: random stall bursts, plus one long hold-off to back the pipe up
   initial begin
      int cycle_count;
      bit quiet;
      cycle_count = 0;
      quiet = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [7:0] ix, iy, slot;
      int         pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table so that no evaluation reads an unwritten entry
      for (int k = 0; k < 256; k++) load_entry(8'(k), 8'($urandom));

      // directed: field extremes, flat full-scale and zero cells, a mixed cell, wrap-round
      load_entry(8'hFF, 8'hFF);
      load_entry(8'h00, 8'h00);
      load_entry(8'd10, 8'd20);
      load_entry(8'd11, 8'd20);
      load_entry(8'd20, 8'hFF);
      load_entry(8'd21, 8'hFF);
      load_entry(8'd12, 8'd22);
      load_entry(8'd13, 8'd22);
      load_entry(8'd22, 8'h00);
      load_entry(8'd23, 8'h00);
      evaluate(16'h0A00, 16'h0000);
      evaluate(16'h0AFF, 16'h00FF);
      evaluate(16'h0C80, 16'h0080);
      evaluate(16'h0B80, 16'h0040);
      evaluate(16'h0BFF, 16'h0001);
      evaluate(16'h0000, 16'h0000);
      evaluate(16'hFFFF, 16'hFFFF);
      evaluate(16'hFF00, 16'h00FF);
      evaluate(16'h00FF, 16'hFF00);
      evaluate(16'hFF80, 16'hFF80);

      // random: plain loads and evaluations, and loads that an evaluation reads at once
      while (items_sent < ITEM_TOTAL) begin
         pick = $urandom_range(0, 9);
         ix   = 8'($urandom);
         iy   = 8'($urandom);
         if (pick < 2) begin
            load_entry(ix, 8'($urandom));
         end else if (pick < 4) begin
            load_entry(ix, 8'($urandom));
            evaluate({ix - 8'($urandom_range(0, 1)), 8'($urandom)}, 16'($urandom));
         end else if (pick == 4) begin
            slot = 8'(shadow[ix] + iy + 8'($urandom_range(0, 1)));
            load_entry(slot, 8'($urandom));
            evaluate({ix, 8'($urandom)}, {iy, 8'($urandom)});
         end else begin
            evaluate(16'($urandom), 16'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (levels_owed != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      $display("Covered %0d table loads and %0d noise evaluations,", loads_sent, evals_sent);
      $display("with random idling on both sides and one long output hold-off.");
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/vn2d_pkg.sv
rtl/vn2d_ram.sv
rtl/value_noise_2d_core.sv
bench/value_noise_2d_checker.sv
bench/testbench.sv
